>>> rtl/core/ogs_pkg.sv
// Shared types, constants and helpers for the orbit gravity step block.
`default_nettype none

package ogs_pkg;

    localparam int DW        = 48;     // state and result word width
    localparam int WW        = 128;    // shared unit datapath width
    localparam int DT_W      = 32;     // step length width
    localparam int SUM_W     = 98;     // signed accumulator for the update sums
    localparam int FRAC_DEF  = 16;

    localparam logic [7:0] MUL_STEPS  = 8'd48;
    localparam logic [7:0] DIV_STEPS  = 8'd128;
    localparam logic [7:0] SQRT_STEPS = 8'd48;

    // configuration register indexes
    localparam logic [1:0] REG_START_POS_X = 2'd0;
    localparam logic [1:0] REG_START_POS_Y = 2'd1;
    localparam logic [1:0] REG_START_VEL_X = 2'd2;
    localparam logic [1:0] REG_START_VEL_Y = 2'd3;

    localparam logic [DW-1:0] START_PX_RST = 48'd0;
    localparam logic [DW-1:0] START_PY_RST = 48'd2763259904000;
    localparam logic [DW-1:0] START_VX_RST = -48'sd203161600;
    localparam logic [DW-1:0] START_VY_RST = 48'd0;

    localparam logic [DW-1:0] MAX48 = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MIN48 = {1'b1, {(DW-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } ogs_op_t;

    typedef struct packed {
        logic    start;
        ogs_op_t op;
    } ogs_req_t;

    typedef struct packed {
        logic          done;
        logic [WW-1:0] result;
    } ogs_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQRT,
        ST_HGT,
        ST_RR,
        ST_GDIV,
        ST_GX_MUL,
        ST_GX_DIV,
        ST_GY_MUL,
        ST_GY_DIV,
        ST_AD,
        ST_AD2,
        ST_VD,
        ST_PSUM1,
        ST_PSUM2,
        ST_VSUM,
        ST_DONE
    } ogs_state_t;

    // Earth radius in raw fixed point
    function automatic logic [WW-1:0] r_raw_f(input int f);
        return WW'(6378000) << f;
    endfunction

    // surface gravity, rounded half up
    function automatic logic [WW-1:0] g0_raw_f(input int f);
        return ((WW'(980665) << f) + WW'(50000)) / WW'(100000);
    endfunction

    // G0 * R^2, numerator of the gravity division
    function automatic logic [WW-1:0] gr2_f(input int f);
        logic [WW-1:0] r;
        r = r_raw_f(f);
        return r * r * g0_raw_f(f);
    endfunction

    function automatic logic [DW-1:0] mag48(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 48'd1) : v;
    endfunction

    // saturate to 48 bits signed; top bit of the result flags saturation
    function automatic logic [DW:0] sat48(input logic [SUM_W-1:0] v);
        logic [SUM_W-DW:0] top;
        top = v[SUM_W-1:DW-1];
        if ((&top) || !(|top)) begin
            return {1'b0, v[DW-1:0]};
        end
        return v[SUM_W-1] ? {1'b1, MIN48} : {1'b1, MAX48};
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ogs_arith.sv
// Shared multi-cycle arithmetic unit: shift-add multiply, restoring divide, square root.
`default_nettype none

module ogs_arith (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ogs_pkg::ogs_req_t       req,
    input  wire logic [ogs_pkg::WW-1:0]  opa,   // multiplicand / numerator / radicand
    input  wire logic [ogs_pkg::DW-1:0]  opb,   // multiplier
    input  wire logic [ogs_pkg::WW-1:0]  opc,   // addend for multiply / divisor
    output ogs_pkg::ogs_rsp_t            rsp
);
    import ogs_pkg::*;

    ogs_op_t       op_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [7:0]    cnt_reg;
    logic [WW-1:0] acc_reg;
    logic [WW-1:0] x_reg;
    logic [WW-1:0] y_reg;
    logic [WW-1:0] q_reg;

    logic [WW-1:0] sh_div;
    logic [WW-1:0] sh_sqrt;
    logic [WW-1:0] trial;
    logic [WW-1:0] add_a;
    logic [WW-1:0] add_b;
    logic          sub;
    logic [WW:0]   sum;
    logic          fits;

    assign sh_div  = {acc_reg[WW-2:0], x_reg[WW-1]};
    assign sh_sqrt = {acc_reg[WW-3:0], x_reg[2*DW-1:2*DW-2]};
    assign trial   = {q_reg[WW-3:0], 2'b01};

    // the one adder everything goes through
    always_comb
    begin
        case (op_reg)
            OP_MUL:
            begin
                add_a = acc_reg;
                add_b = x_reg;
                sub   = 1'b0;
            end
            OP_DIV:
            begin
                add_a = sh_div;
                add_b = y_reg;
                sub   = 1'b1;
            end
            OP_SQRT:
            begin
                add_a = sh_sqrt;
                add_b = trial;
                sub   = 1'b1;
            end
            default:
            begin
                add_a = acc_reg;
                add_b = x_reg;
                sub   = 1'b0;
            end
        endcase
        sum  = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{WW{1'b0}}, sub};
        fits = sum[WW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            // last iteration ends this cycle
            done_reg <= !req.start && busy_reg && (cnt_reg == 8'd1);
            if (req.start)
            begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                case (req.op)
                    OP_MUL:  cnt_reg <= MUL_STEPS;
                    OP_DIV:  cnt_reg <= DIV_STEPS;
                    OP_SQRT: cnt_reg <= SQRT_STEPS;
                    default: cnt_reg <= MUL_STEPS;
                endcase
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 8'd1;
                if (cnt_reg == 8'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            acc_reg <= (req.op == OP_MUL) ? opc : '0;
            x_reg   <= opa;
            y_reg   <= (req.op == OP_MUL) ? WW'(opb) : opc;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_reg <= sum[WW-1:0];
                    end
                    x_reg <= x_reg << 1;
                    y_reg <= y_reg >> 1;
                end
                OP_DIV:
                begin
                    acc_reg <= fits ? sum[WW-1:0] : sh_div;
                    q_reg   <= {q_reg[WW-2:0], fits};
                    x_reg   <= x_reg << 1;
                end
                OP_SQRT:
                begin
                    acc_reg <= fits ? sum[WW-1:0] : sh_sqrt;
                    q_reg   <= {q_reg[WW-2:0], fits};
                    x_reg   <= x_reg << 2;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_MUL) ? acc_reg : q_reg;

endmodule

`default_nettype wire

>>> rtl/core/orbit_gravity_step.sv
// Orbit gravity step: sequencer, body state and output register around the shared unit.
//
// Channel   Dir  Beat contents (low bits first)
// s_*       in   tdata: time_step[31:0]; tuser: restart
// m_*       out  tdata: pos_x, pos_y, vel_x, vel_y, height (48 b each); tuser: fault
// cfg_*     in   write enable, register index, 48-bit write data
//
// A restart beat goes straight to the done state and then into the output
// register once that is free. A normal step runs on the shared unit: each
// multiply or the square root takes 48 iterations and each divide 128, each
// between a start and a done; eleven multiplies, one root and three divides,
// plus the height step, six update-sum steps and the output step.
// rst_n clears the sequencer and loads the body and start registers with their
// defaults. s_tready is high only when the sequencer is idle; a result waiting
// in the output register does not block the next beat, but a finished step
// waits for that register to be free.
`default_nettype none

module orbit_gravity_step #(
    parameter int FRAC_BITS = ogs_pkg::FRAC_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [31:0]   s_tdata,   // time_step[31:0]
    input  wire logic [0:0]    s_tuser,   // restart
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [239:0]       m_tdata,   // pos_x, pos_y, vel_x, vel_y, height_out
    output logic [0:0]         m_tuser,   // fault
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [47:0]   cfg_wdata
);
    import ogs_pkg::*;

    localparam logic [DW-1:0] R_RAW = DW'(r_raw_f(FRAC_BITS));
    localparam logic [WW-1:0] GR2   = gr2_f(FRAC_BITS);

    ogs_state_t state_reg, state_next;

    logic [DW-1:0] start_px_reg, start_py_reg, start_vx_reg, start_vy_reg;
    logic [DW-1:0] body_x_reg, body_y_reg, body_vx_reg, body_vy_reg;
    logic [DT_W-1:0] dt_reg;
    logic          run_reg;
    logic          axis_reg;     // 0: x axis, 1: y axis
    logic          flt_reg;
    logic          a_neg_reg;
    logic [WW-1:0] t_reg;
    logic [DW-1:0] r_reg, g_reg, ax_reg, ay_reg, hgt_reg;
    logic [WW-1:0] ad_reg, ad2_reg, vd_reg;
    logic [SUM_W-1:0] acc_reg;

    logic          m_valid_reg;
    logic [239:0]  m_data_reg;
    logic          m_fault_reg;

    ogs_req_t      req;
    ogs_rsp_t      rsp;
    logic [WW-1:0] opa, opc;
    logic [DW-1:0] opb;
    logic          unit_state;

    logic          accept;
    logic [DW-1:0] p_cur, v_cur, a_mag;
    logic          a_neg;
    logic [SUM_W-1:0] sum_a, term, sum;
    logic          term_neg;
    logic [DW:0]   sat_res;
    logic [DW:0]   hdiff;

    assign accept = s_tvalid && s_tready;

    assign p_cur = axis_reg ? body_y_reg : body_x_reg;
    assign v_cur = axis_reg ? body_vy_reg : body_vx_reg;
    assign a_mag = axis_reg ? ay_reg : ax_reg;
    assign a_neg = a_neg_reg;

    ogs_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .opa   (opa),
        .opb   (opb),
        .opc   (opc),
        .rsp   (rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = s_tuser[0] ? ST_DONE : ST_SQ_X;
            ST_SQ_X:   if (rsp.done) state_next = ST_SQ_Y;
            ST_SQ_Y:   if (rsp.done) state_next = ST_SQRT;
            ST_SQRT:   if (rsp.done) state_next = ST_HGT;
            ST_HGT:    state_next = (r_reg == '0) ? ST_DONE : ST_RR;
            ST_RR:     if (rsp.done) state_next = ST_GDIV;
            ST_GDIV:   if (rsp.done) state_next = ST_GX_MUL;
            ST_GX_MUL: if (rsp.done) state_next = ST_GX_DIV;
            ST_GX_DIV: if (rsp.done) state_next = ST_GY_MUL;
            ST_GY_MUL: if (rsp.done) state_next = ST_GY_DIV;
            ST_GY_DIV: if (rsp.done) state_next = ST_AD;
            ST_AD:     if (rsp.done) state_next = ST_AD2;
            ST_AD2:    if (rsp.done) state_next = ST_VD;
            ST_VD:     if (rsp.done) state_next = ST_PSUM1;
            ST_PSUM1:  state_next = ST_PSUM2;
            ST_PSUM2:  state_next = ST_VSUM;
            ST_VSUM:   state_next = axis_reg ? ST_DONE : ST_AD;
            ST_DONE:   if (!m_valid_reg || m_tready) state_next = ST_IDLE;
        endcase
    end

    // unit requests and sum operands
    always_comb
    begin
        unit_state = 1'b1;
        req.op     = OP_MUL;
        opa        = '0;
        opb        = '0;
        opc        = '0;
        sum_a      = '0;
        term       = '0;
        term_neg   = 1'b0;
        unique case (state_reg)
            ST_SQ_X:
            begin
                opa = WW'(mag48(body_x_reg));
                opb = mag48(body_x_reg);
            end
            ST_SQ_Y:
            begin
                opa = WW'(mag48(body_y_reg));
                opb = mag48(body_y_reg);
                opc = t_reg;
            end
            ST_SQRT:
            begin
                req.op = OP_SQRT;
                opa    = t_reg;
            end
            ST_RR:
            begin
                opa = WW'(r_reg);
                opb = r_reg;
            end
            ST_GDIV:
            begin
                req.op = OP_DIV;
                opa    = GR2;
                opc    = t_reg;
            end
            ST_GX_MUL:
            begin
                opa = WW'(g_reg);
                opb = mag48(body_x_reg);
            end
            ST_GY_MUL:
            begin
                opa = WW'(g_reg);
                opb = mag48(body_y_reg);
            end
            ST_GX_DIV, ST_GY_DIV:
            begin
                req.op = OP_DIV;
                opa    = t_reg;
                opc    = WW'(r_reg);
            end
            ST_AD:
            begin
                opa = WW'(a_mag);
                opb = DW'(dt_reg);
            end
            ST_AD2:
            begin
                opa = ad_reg;
                opb = DW'(dt_reg);
            end
            ST_VD:
            begin
                opa = WW'(mag48(v_cur));
                opb = DW'(dt_reg);
            end
            ST_PSUM1:
            begin
                unit_state = 1'b0;
                sum_a      = {{(SUM_W-DW){p_cur[DW-1]}}, p_cur};
                term       = SUM_W'(vd_reg >> FRAC_BITS);
                term_neg   = v_cur[DW-1];
            end
            ST_PSUM2:
            begin
                unit_state = 1'b0;
                sum_a      = acc_reg;
                term       = SUM_W'(ad2_reg >> (2 * FRAC_BITS + 1));
                term_neg   = a_neg;
            end
            ST_VSUM:
            begin
                unit_state = 1'b0;
                sum_a      = {{(SUM_W-DW){v_cur[DW-1]}}, v_cur};
                term       = SUM_W'(ad_reg >> FRAC_BITS);
                term_neg   = a_neg;
            end
            ST_IDLE, ST_HGT, ST_DONE:
            begin
                unit_state = 1'b0;
            end
        endcase
        req.start = unit_state && !run_reg;
        sum       = sum_a + (term_neg ? ~term : term) + SUM_W'(term_neg);
        sat_res   = sat48(sum);
        hdiff     = {1'b0, r_reg} - {1'b0, R_RAW};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            run_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            start_px_reg <= START_PX_RST;
            start_py_reg <= START_PY_RST;
            start_vx_reg <= START_VX_RST;
            start_vy_reg <= START_VY_RST;
            body_x_reg   <= START_PX_RST;
            body_y_reg   <= START_PY_RST;
            body_vx_reg  <= START_VX_RST;
            body_vy_reg  <= START_VY_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (req.start)
            begin
                run_reg <= 1'b1;
            end
            else if (rsp.done)
            begin
                run_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_START_POS_X: start_px_reg <= cfg_wdata;
                    REG_START_POS_Y: start_py_reg <= cfg_wdata;
                    REG_START_VEL_X: start_vx_reg <= cfg_wdata;
                    REG_START_VEL_Y: start_vy_reg <= cfg_wdata;
                endcase
            end

            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (accept && s_tuser[0])
            begin
                body_x_reg  <= start_px_reg;
                body_y_reg  <= start_py_reg;
                body_vx_reg <= start_vx_reg;
                body_vy_reg <= start_vy_reg;
            end
            // position first, then velocity: the position term needs the old velocity
            if (state_reg == ST_PSUM2)
            begin
                if (axis_reg) body_y_reg <= sat_res[DW-1:0];
                else          body_x_reg <= sat_res[DW-1:0];
            end
            if (state_reg == ST_VSUM)
            begin
                if (axis_reg) body_vy_reg <= sat_res[DW-1:0];
                else          body_vx_reg <= sat_res[DW-1:0];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dt_reg   <= s_tdata;
            flt_reg  <= 1'b0;
            hgt_reg  <= '0;
            axis_reg <= 1'b0;
        end
        unique case (state_reg)
            ST_SQ_X, ST_SQ_Y, ST_RR, ST_GX_MUL, ST_GY_MUL:
            begin
                if (rsp.done) t_reg <= rsp.result;
            end
            ST_SQRT:
            begin
                if (rsp.done) r_reg <= rsp.result[DW-1:0];
            end
            ST_HGT:
            begin
                if (r_reg == '0)
                begin
                    flt_reg <= 1'b1;
                    hgt_reg <= hdiff[DW-1:0];
                end
                else if (!hdiff[DW] && hdiff[DW-1])
                begin
                    flt_reg <= 1'b1;
                    hgt_reg <= MAX48;
                end
                else
                begin
                    hgt_reg <= hdiff[DW-1:0];
                end
            end
            ST_GDIV:
            begin
                if (rsp.done)
                begin
                    if (|rsp.result[WW-1:DW-1])
                    begin
                        g_reg   <= MAX48;
                        flt_reg <= 1'b1;
                    end
                    else
                    begin
                        g_reg <= rsp.result[DW-1:0];
                    end
                end
            end
            ST_GX_DIV:
            begin
                if (rsp.done) ax_reg <= rsp.result[DW-1:0];
            end
            ST_GY_DIV:
            begin
                if (rsp.done) ay_reg <= rsp.result[DW-1:0];
            end
            ST_AD:
            begin
                if (rsp.done) ad_reg <= rsp.result;
                // acceleration points back at the center; taken from the old position
                a_neg_reg <= ~p_cur[DW-1];
            end
            ST_AD2:
            begin
                if (rsp.done) ad2_reg <= rsp.result;
            end
            ST_VD:
            begin
                if (rsp.done) vd_reg <= rsp.result;
            end
            ST_PSUM1:
            begin
                acc_reg <= sum;
            end
            ST_PSUM2:
            begin
                if (sat_res[DW]) flt_reg <= 1'b1;
            end
            ST_VSUM:
            begin
                if (sat_res[DW]) flt_reg <= 1'b1;
                axis_reg <= 1'b1;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_data_reg  <= {hgt_reg, body_vy_reg, body_vx_reg, body_y_reg, body_x_reg};
                    m_fault_reg <= flt_reg;
                end
            end
            ST_IDLE:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_fault_reg;

endmodule

`default_nettype wire

>>> rtl/core/ogs_checker.sv
// Port-level checks for the orbit gravity step block, bound to the top level.
`default_nettype none

module ogs_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [239:0] m_tdata,
    input wire logic [0:0]   m_tuser
);

    // one step at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a step is in progress");

    // no result in the cycle right after a beat is taken while none was waiting
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // a new result comes with the sequencer back in idle
    a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while still busy");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

endmodule

bind orbit_gravity_step ogs_checker u_ogs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
